/* hdl/h2p_pkg.sv */
// Shared types, constants and functions for the hash-to-point sampler.
package h2p_pkg;

  // Channel payload widths
  localparam int unsigned WordW  = 16;
  localparam int unsigned IndexW = 10;
  localparam int unsigned CountW = 11;
  localparam int unsigned LogW   = 4;
  localparam int unsigned OverW  = 9;

  // Configuration port
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] CFG_LOG_DEGREE   = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_BOUNDED_MODE = 8'd1;

  // Arithmetic constants
  localparam logic [WordW-1:0]  Q_MOD        = 16'd12289;
  localparam logic [WordW-1:0]  TWO_Q        = 16'd24578;
  localparam logic [WordW-1:0]  ACCEPT_LIMIT = 16'd61445;
  localparam logic [WordW-1:0]  NO_VALUE     = 16'hFFFF;
  localparam logic [CountW-1:0] COUNT_MAX    = 11'd2047;
  localparam logic [LogW-1:0]   LOG_RESET    = 4'd9;

  // Limits derived from the configuration registers
  typedef struct packed {
    logic [CountW-1:0] n;
    logic [CountW-1:0] budget;
    logic              bounded;
  } h2p_limits_t;

  // Oversampling allowance per log degree (1..10)
  function automatic logic [OverW-1:0] over_entry(input logic [LogW-1:0] l);
    logic [OverW-1:0] v;
    unique case (l)
      4'd2:    v = 9'd67;
      4'd3:    v = 9'd71;
      4'd4:    v = 9'd77;
      4'd5:    v = 9'd86;
      4'd6:    v = 9'd100;
      4'd7:    v = 9'd122;
      4'd8:    v = 9'd154;
      4'd9:    v = 9'd205;
      4'd10:   v = 9'd287;
      default: v = 9'd65;
    endcase
    return v;
  endfunction

  // Reduce a word below 5q to [0, q) with three fixed conditional subtractions
  function automatic logic [WordW-1:0] reduce_q(input logic [WordW-1:0] w);
    logic [WordW-1:0] r;
    r = w;
    if (r >= TWO_Q) r = r - TWO_Q;
    if (r >= TWO_Q) r = r - TWO_Q;
    if (r >= Q_MOD) r = r - Q_MOD;
    return r;
  endfunction

endpackage

/* hdl/h2p_if.sv */
// Handshake channel interfaces: hash words in, coefficients out, config writes.
interface h2p_word_if;
  logic                      valid;
  logic                      ready;
  logic [h2p_pkg::WordW-1:0] random_word;
  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

interface h2p_coeff_if;
  logic                       valid;
  logic                       ready;
  logic [h2p_pkg::WordW-1:0]  coefficient;
  logic [h2p_pkg::IndexW-1:0] coeff_index;
  logic                       last;
  logic                       shortfall;
  modport source (output valid, output coefficient, output coeff_index,
                  output last, output shortfall, input ready);
  modport sink   (input valid, input coefficient, input coeff_index,
                  input last, input shortfall, output ready);
endinterface

interface h2p_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [h2p_pkg::CfgIdxW-1:0]  index;
  logic [h2p_pkg::CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/h2p_cfg.sv */
// Configuration registers and the coefficient count and sample budget they imply.
module h2p_cfg #(
  parameter int unsigned MAX_LOG_DEGREE = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  h2p_cfg_if.sink              cfg_i,
  output h2p_pkg::h2p_limits_t limits_o
);
  import h2p_pkg::*;

  logic [LogW-1:0] log_degree_q;
  logic            bounded_q;
  logic [LogW-1:0] log_eff;

  // Writes are always taken; unknown indexes are dropped
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_degree_q <= LOG_RESET;
      bounded_q    <= 1'b1;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_LOG_DEGREE) begin
        log_degree_q <= cfg_i.data[LogW-1:0];
      end else if (cfg_i.index == CFG_BOUNDED_MODE) begin
        bounded_q <= cfg_i.data[0];
      end
    end
  end

  // Clamp the degree into the supported range
  always_comb begin
    priority if (log_degree_q == '0) begin
      log_eff = 4'd1;
    end else if (log_degree_q > LogW'(MAX_LOG_DEGREE)) begin
      log_eff = LogW'(MAX_LOG_DEGREE);
    end else begin
      log_eff = log_degree_q;
    end
  end

  // n = 2^l, budget = n + oversampling allowance
  assign limits_o.n       = CountW'(1) << log_eff;
  assign limits_o.budget  = limits_o.n + CountW'(over_entry(log_eff));
  assign limits_o.bounded = bounded_q;

endmodule

/* hdl/hash_to_point_sampler.sv */
// Top level: rejection sampler turning hash words into coefficients mod 12289.
//
// Usage:
//   sample_i carries one 16-bit hash word per beat (first hash byte high).
//   result_o carries one coefficient per accepted word, with its index in the
//   polynomial; last marks the final coefficient. In bounded mode, if the
//   word budget (n plus the oversampling allowance) runs out first, a single
//   beat with coefficient 65535, last and shortfall set ends the polynomial.
//   Words of 61445 and above are dropped; one gives a beat only if it ends the budget.
//   cfg_i writes log_degree (index 0) and bounded_mode (index 1); write only
//   while the block is idle. The port is always ready.
// Timing:
//   One word per cycle sustained while result_o is not held. An accepted word is
//   registered in the input register, then the single counter/reduction stage
//   writes the result register, where the beat stays valid until it is taken.
// Reset: both counters clear, log_degree = 9, bounded_mode = 1.
// Stall: while result_o is held the result register keeps its beat, the
//   input register holds one more word, and sample_i.ready drops.
module hash_to_point_sampler #(
  parameter int unsigned MAX_LOG_DEGREE = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  h2p_word_if.sink    sample_i,
  h2p_coeff_if.source result_o,
  h2p_cfg_if.sink     cfg_i
);
  import h2p_pkg::*;

  h2p_limits_t limits;

  logic              in_valid_q;
  logic [WordW-1:0]  word_q;
  logic              out_valid_q;
  logic [WordW-1:0]  coeff_q, coeff_d;
  logic [IndexW-1:0] index_q;
  logic              last_q, last_d;
  logic              short_q, short_d;
  logic [CountW-1:0] acc_q, acc_d;
  logic [CountW-1:0] smp_q, smp_d;

  logic              out_free;
  logic              step;
  logic              emit;
  logic              word_ok;
  logic              exhaust;
  logic              done;
  logic [CountW-1:0] smp_inc;
  logic [CountW-1:0] acc_inc;

  h2p_cfg #(
    .MAX_LOG_DEGREE(MAX_LOG_DEGREE)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_i),
    .limits_o(limits)
  );

  // Handshake: the stage advances when the result slot is free or draining
  assign out_free       = !out_valid_q || result_o.ready;
  assign step           = in_valid_q && out_free;
  assign sample_i.ready = !in_valid_q || step;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (sample_i.ready) begin
      in_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.ready && sample_i.valid) begin
      word_q <= sample_i.random_word;
    end
  end

  // Sampling decision for the word in the input register
  assign smp_inc = (smp_q == COUNT_MAX) ? smp_q : smp_q + CountW'(1);
  assign acc_inc = acc_q + CountW'(1);
  assign word_ok = word_q < ACCEPT_LIMIT;
  assign done    = acc_inc >= limits.n;
  // in bounded mode, budget gone and this word does not finish the polynomial
  assign exhaust = limits.bounded && (smp_inc >= limits.budget)
                   && !(word_ok && done) && (acc_q < limits.n);
  assign emit    = exhaust || word_ok;

  always_comb begin
    coeff_d = reduce_q(word_q);
    last_d  = done;
    short_d = 1'b0;
    acc_d   = acc_q;
    smp_d   = smp_inc;
    priority if (exhaust) begin
      coeff_d = NO_VALUE;
      last_d  = 1'b1;
      short_d = 1'b1;
      acc_d   = '0;
      smp_d   = '0;
    end else if (word_ok && done) begin
      acc_d = '0;
      smp_d = '0;
    end else if (word_ok) begin
      acc_d = acc_inc;
    end else begin
      acc_d = acc_q;
    end
  end

  // Counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      smp_q <= '0;
    end else if (step) begin
      acc_q <= acc_d;
      smp_q <= smp_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      coeff_q <= coeff_d;
      index_q <= acc_q[IndexW-1:0];
      last_q  <= last_d;
      short_q <= short_d;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.coefficient = coeff_q;
  assign result_o.coeff_index = index_q;
  assign result_o.last        = last_q;
  assign result_o.shortfall   = short_q;

`ifndef ASSERT_OFF
  // A shortfall beat always closes the polynomial with the filler value
  a_short_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && short_q) |-> (last_q && coeff_q == NO_VALUE))
    else $error("shortfall beat without last or filler value");

  // Ordinary coefficients are fully reduced
  a_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !short_q) |-> (coeff_q < Q_MOD))
    else $error("coefficient not reduced mod q");

  // Closing a polynomial restarts both counters
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && emit && last_d) |=> (acc_q == '0 && smp_q == '0))
    else $error("counters not cleared after last coefficient");

  // Accepted count never passes the largest degree
  a_acc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q <= (CountW'(1) << MAX_LOG_DEGREE))
    else $error("accepted count out of range");
`endif

endmodule
